[hdl/assert_macros.svh]
// assertion macros used by the top-level rtl file
// each use expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent in a cycle implies consequent in the same cycle
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[hdl/iesj_pkg.sv]
// types, codes and the compare function of the inequality self-join block
// no dependencies
package iesj_pkg;

    localparam int MAX_ROWS_DEF = 64;
    localparam int ROW_W        = 6;
    localparam int VAL_W        = 32;
    localparam int WIDE_W       = ROW_W + 1;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 2;

    typedef enum logic [1:0] {
        CMP_LT = 2'd0,
        CMP_LE = 2'd1,
        CMP_GT = 2'd2,
        CMP_GE = 2'd3
    } cmp_op_t;

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_PROBE = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        STAT_LOADED   = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_PAIR     = 3'd2,
        STAT_NOMATCH  = 3'd3,
        STAT_BAD_ROW  = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIRST_OP  = 2'd0,
        REG_SECOND_OP = 2'd1
    } cfg_reg_t;

    // per-cycle commands broadcast to every cell
    typedef struct packed {
        logic we;
        logic load_fetch;
        logic shift_fetch;
        logic compare;
        logic shift_match;
    } cell_ctrl_t;

    function automatic logic cmp_test(cmp_op_t op, logic signed [VAL_W-1:0] a,
                                      logic signed [VAL_W-1:0] b);
        logic r;
        unique case (op)
            CMP_LT:  r = (a < b);
            CMP_LE:  r = (a <= b);
            CMP_GT:  r = (a > b);
            CMP_GE:  r = (a >= b);
            default: r = (a >= b);
        endcase
        return r;
    endfunction

endpackage

[hdl/iesj_cell.sv]
// one table cell: holds one row, a fetch shift stage and a match bit
// depends on iesj_pkg
module iesj_cell
    import iesj_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cell_ctrl_t                    ctrl,
    input  logic [$clog2(MAX_ROWS)-1:0]   position,
    input  logic [$clog2(MAX_ROWS)-1:0]   wr_idx,
    input  logic [$clog2(MAX_ROWS+1)-1:0] count,
    input  logic signed [VAL_W-1:0]       wr_x,
    input  logic signed [VAL_W-1:0]       wr_y,
    input  logic signed [VAL_W-1:0]       probe_x,
    input  logic signed [VAL_W-1:0]       probe_y,
    input  cmp_op_t                       op1,
    input  cmp_op_t                       op2,
    input  logic signed [VAL_W-1:0]       fetch_x_in,
    input  logic signed [VAL_W-1:0]       fetch_y_in,
    output logic signed [VAL_W-1:0]       fetch_x_out,
    output logic signed [VAL_W-1:0]       fetch_y_out,
    input  logic                          match_in,
    output logic                          match_out
);

    localparam int CNT_W = $clog2(MAX_ROWS + 1);

    logic signed [VAL_W-1:0] x_reg, y_reg;
    logic signed [VAL_W-1:0] fx_reg, fy_reg;
    logic                    match_reg, match_next;
    logic                    occupied;

    assign occupied = (CNT_W'(position) < count);

    always_ff @(posedge clk)
    begin
        if (ctrl.we && (wr_idx == position))
        begin
            x_reg <= wr_x;
            y_reg <= wr_y;
        end
        if (ctrl.load_fetch)
        begin
            fx_reg <= x_reg;
            fy_reg <= y_reg;
        end
        else if (ctrl.shift_fetch)
        begin
            fx_reg <= fetch_x_in;
            fy_reg <= fetch_y_in;
        end
    end

    always_comb
    begin
        match_next = match_reg;
        if (ctrl.compare)
            match_next = occupied && cmp_test(op1, probe_x, x_reg)
                                  && cmp_test(op2, probe_y, y_reg);
        else if (ctrl.shift_match)
            match_next = match_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            match_reg <= 1'b0;
        else
            match_reg <= match_next;
    end

    assign fetch_x_out = fx_reg;
    assign fetch_y_out = fy_reg;
    assign match_out   = match_reg;

endmodule

[hdl/inequality_self_join.sv]
// inequality self-join: top level with controller, cell chain and output register
// depends on iesj_pkg, iesj_cell and assert_macros.svh
//
// Usage
//   input channel (in_valid / in_stall) carries func, x_value, y_value, probe_row.
//   output channel (out_valid / out_stall) carries status, row_id, partner_row, last.
//   cfg channel (cfg_valid / cfg_ready) writes the two compare operators; it is
//   always ready and must only be used while the block is idle.
//   A load or a rejected probe takes one word in; its result word goes through the
//   S_SINGLE state into the output word register once that is free, and the next
//   word is taken once the controller is idle. A clear gives nothing and stays idle.
//   A valid probe of row r walks row r down the cell chain to cell 0 and captures
//   it, compares in every cell at once and then shifts the match bits out of the
//   chain, one cell a cycle while the output is not stalled, over row_count cells;
//   the S_FINISH state then registers the final word, and the next word is taken
//   once the controller is back in idle. Pairs come out in ascending row order;
//   last marks the final word. One item is worked on at a time; in_stall is
//   high unless the controller is idle. A stalled output word holds and the
//   scan pauses behind it.
//   Reset empties the table and sets the operators to greater / less.
module inequality_self_join
    import iesj_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              func,
    input  logic signed [VAL_W-1:0] x_value,
    input  logic signed [VAL_W-1:0] y_value,
    input  logic [ROW_W-1:0]        probe_row,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [2:0]              status,
    output logic [ROW_W-1:0]        row_id,
    output logic [ROW_W-1:0]        partner_row,
    output logic                    last,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

`include "assert_macros.svh"

    localparam int IDX_W = $clog2(MAX_ROWS);
    localparam int CNT_W = $clog2(MAX_ROWS + 1);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_SINGLE  = 6'b000010,
        S_FETCH   = 6'b000100,
        S_COMPARE = 6'b001000,
        S_SCAN    = 6'b010000,
        S_FINISH  = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    cmp_op_t             op1_reg, op2_reg;
    logic [IDX_W-1:0]    fcnt_reg, fcnt_next;
    logic [IDX_W-1:0]    scan_reg, scan_next;
    logic                pend_reg, pend_next;
    logic [IDX_W-1:0]    pidx_reg, pidx_next;
    status_t             rstat_reg, rstat_next;
    logic [ROW_W-1:0]    rleft_reg, rleft_next;
    logic signed [VAL_W-1:0] px_reg, py_reg;
    logic                capture;

    logic                ov_reg, ov_next;
    status_t             ostat_reg;
    logic [ROW_W-1:0]    oleft_reg, oright_reg;
    logic                olast_reg;

    logic                accept, out_free, emit, scan_end;
    status_t             e_stat;
    logic [ROW_W-1:0]    e_left, e_right;
    logic                e_last;
    cell_ctrl_t          cctrl;

    logic signed [VAL_W-1:0] fx [MAX_ROWS+1];
    logic signed [VAL_W-1:0] fy [MAX_ROWS+1];
    logic                    mch [MAX_ROWS+1];

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !ov_reg || !out_stall;
    assign cfg_ready = 1'b1;
    assign scan_end  = (CNT_W'(scan_reg) == (count_reg - CNT_W'(1)));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op1_reg <= CMP_GT;
            op2_reg <= CMP_LT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FIRST_OP:  op1_reg <= cmp_op_t'(cfg_data);
                REG_SECOND_OP: op2_reg <= cmp_op_t'(cfg_data);
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        fcnt_next  = fcnt_reg;
        scan_next  = scan_reg;
        pend_next  = pend_reg;
        pidx_next  = pidx_reg;
        rstat_next = rstat_reg;
        rleft_next = rleft_reg;
        cctrl      = '0;
        capture    = 1'b0;
        emit       = 1'b0;
        e_stat     = rstat_reg;
        e_left     = rleft_reg;
        e_right    = '0;
        e_last     = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (func)
                        FUNC_LOAD:
                        begin
                            state_next = S_SINGLE;
                            rleft_next = '0;
                            if (count_reg >= CNT_W'(MAX_ROWS))
                                rstat_next = STAT_FULL;
                            else
                            begin
                                rstat_next = STAT_LOADED;
                                rleft_next = ROW_W'(count_reg);
                                cctrl.we   = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        FUNC_PROBE:
                        begin
                            rleft_next = probe_row;
                            if (WIDE_W'(probe_row) >= WIDE_W'(count_reg))
                            begin
                                rstat_next = STAT_BAD_ROW;
                                state_next = S_SINGLE;
                            end
                            else
                            begin
                                cctrl.load_fetch = 1'b1;
                                fcnt_next  = probe_row[IDX_W-1:0];
                                state_next = S_FETCH;
                            end
                        end
                        FUNC_CLEAR:
                            count_next = '0;
                        default:
                            ;
                    endcase
                end
            end
            S_SINGLE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FETCH:
            begin
                if (fcnt_reg == '0)
                begin
                    capture    = 1'b1;
                    state_next = S_COMPARE;
                end
                else
                begin
                    cctrl.shift_fetch = 1'b1;
                    fcnt_next = fcnt_reg - IDX_W'(1);
                end
            end
            S_COMPARE:
            begin
                cctrl.compare = 1'b1;
                scan_next  = '0;
                pend_next  = 1'b0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // a found pair is held back one match so that last can be set
                if (out_free)
                begin
                    cctrl.shift_match = 1'b1;
                    if (mch[0])
                    begin
                        emit      = pend_reg;
                        e_stat    = STAT_PAIR;
                        e_right   = ROW_W'(pidx_reg);
                        e_last    = 1'b0;
                        pend_next = 1'b1;
                        pidx_next = scan_reg;
                    end
                    scan_next = scan_reg + IDX_W'(1);
                    if (scan_end)
                        state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (pend_reg)
                    begin
                        e_stat  = STAT_PAIR;
                        e_right = ROW_W'(pidx_reg);
                    end
                    else
                        e_stat = STAT_NOMATCH;
                    pend_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            fcnt_reg  <= '0;
            scan_reg  <= '0;
            pend_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            fcnt_reg  <= fcnt_next;
            scan_reg  <= scan_next;
            pend_reg  <= pend_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg  <= pidx_next;
        rstat_reg <= rstat_next;
        rleft_reg <= rleft_next;
        if (capture)
        begin
            px_reg <= fx[0];
            py_reg <= fy[0];
        end
        if (emit)
        begin
            ostat_reg  <= e_stat;
            oleft_reg  <= e_left;
            oright_reg <= e_right;
            olast_reg  <= e_last;
        end
    end

    // output word register
    always_comb
    begin
        ov_next = ov_reg && out_stall;
        if (emit)
            ov_next = 1'b1;
    end

    assign out_valid   = ov_reg;
    assign status      = ostat_reg;
    assign row_id      = oleft_reg;
    assign partner_row = oright_reg;
    assign last        = olast_reg;

    // cell chain: fetch words and match bits move towards cell 0
    assign fx[MAX_ROWS]  = '0;
    assign fy[MAX_ROWS]  = '0;
    assign mch[MAX_ROWS] = 1'b0;

    for (genvar i = 0; i < MAX_ROWS; i++)
    begin : g_cell
        iesj_cell #(
            .MAX_ROWS (MAX_ROWS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (cctrl),
            .position    (IDX_W'(i)),
            .wr_idx      (count_reg[IDX_W-1:0]),
            .count       (count_reg),
            .wr_x        (x_value),
            .wr_y        (y_value),
            .probe_x     (px_reg),
            .probe_y     (py_reg),
            .op1         (op1_reg),
            .op2         (op2_reg),
            .fetch_x_in  (fx[i+1]),
            .fetch_y_in  (fy[i+1]),
            .fetch_x_out (fx[i]),
            .fetch_y_out (fy[i]),
            .match_in    (mch[i+1]),
            .match_out   (mch[i])
        );
    end

    `ASSERT_ALWAYS(a_count_range, count_reg <= CNT_W'(MAX_ROWS), "row count beyond table size")
    `ASSERT_IMPL(a_emit_free, emit, out_free, "word emitted over a stalled output word")
    `ASSERT_IMPL(a_scan_range, state_reg == S_SCAN, CNT_W'(scan_reg) < count_reg,
                 "scan index beyond loaded rows")
    `ASSERT_IMPL(a_pend_state, pend_reg, state_reg == S_SCAN || state_reg == S_FINISH,
                 "pending pair outside a scan")
    `ASSERT_IMPL(a_probe_fits, state_reg == S_FETCH, CNT_W'(fcnt_reg) < count_reg,
                 "probed row not loaded")

endmodule

[tb/sv/inequality_self_join_tb.sv]
`timescale 1ns / 1ps
// testbench for inequality_self_join: loads rows, probes them and checks every result word
// against a local model of the table; depends on iesj_pkg and the block's rtl
module inequality_self_join_tb;
    import iesj_pkg::*;

    localparam int SCAN_CYCLES = 2 * MAX_ROWS_DEF + 8;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [1:0]              fn;
        logic signed [VAL_W-1:0] xv;
        logic signed [VAL_W-1:0] yv;
        logic [ROW_W-1:0]        prow;
    } request_t;

    typedef struct packed {
        status_t          st;
        logic [ROW_W-1:0] lrow;
        logic [ROW_W-1:0] rrow;
        logic             fin;
    } join_word_t;

    logic                    clk;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    logic [1:0]              func      = '0;
    logic signed [VAL_W-1:0] x_value   = '0;
    logic signed [VAL_W-1:0] y_value   = '0;
    logic [ROW_W-1:0]        probe_row = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [2:0]              status;
    logic [ROW_W-1:0]        row_id;
    logic [ROW_W-1:0]        partner_row;
    logic                    last;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;

    // local copy of the table and operators
    logic signed [VAL_W-1:0] row_x [MAX_ROWS_DEF];
    logic signed [VAL_W-1:0] row_y [MAX_ROWS_DEF];
    int                      rows_held = 0;
    cmp_op_t                 op_x = CMP_GT;
    cmp_op_t                 op_y = CMP_LT;

    join_word_t pending_words[$];
    int         fault_count    = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;

    inequality_self_join #(
        .MAX_ROWS (MAX_ROWS_DEF)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .x_value     (x_value),
        .y_value     (y_value),
        .probe_row   (probe_row),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .row_id      (row_id),
        .partner_row (partner_row),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic bit satisfies(cmp_op_t op, logic signed [VAL_W-1:0] a,
                                     logic signed [VAL_W-1:0] b);
        case (op)
            CMP_LT:  return a < b;
            CMP_LE:  return a <= b;
            CMP_GT:  return a > b;
            default: return a >= b;
        endcase
    endfunction

    function automatic bit pair_holds(int r, int s);
        return satisfies(op_x, row_x[r], row_x[s]) && satisfies(op_y, row_y[r], row_y[s]);
    endfunction

    function automatic void queue_word(join_word_t w);
        pending_words.insert(pending_words.size(), w);
    endfunction

    // queue the words one accepted request gives and update the table
    function automatic void predict_words(request_t rq);
        int s;
        int last_hit;
        case (rq.fn)
            FUNC_LOAD:
            begin
                if (rows_held >= MAX_ROWS_DEF)
                    queue_word('{st: STAT_FULL, lrow: '0, rrow: '0, fin: 1'b1});
                else
                begin
                    row_x[rows_held] = rq.xv;
                    row_y[rows_held] = rq.yv;
                    queue_word('{st: STAT_LOADED, lrow: ROW_W'(rows_held),
                                 rrow: '0, fin: 1'b1});
                    rows_held++;
                end
            end
            FUNC_PROBE:
            begin
                if (rq.prow >= rows_held)
                    queue_word('{st: STAT_BAD_ROW, lrow: rq.prow, rrow: '0, fin: 1'b1});
                else
                begin
                    last_hit = -1;
                    for (s = 0; s < rows_held; s++)
                        if (pair_holds(rq.prow, s))
                            last_hit = s;
                    if (last_hit < 0)
                        queue_word('{st: STAT_NOMATCH, lrow: rq.prow, rrow: '0, fin: 1'b1});
                    else
                        for (s = 0; s <= last_hit; s++)
                            if (pair_holds(rq.prow, s))
                                queue_word('{st: STAT_PAIR, lrow: rq.prow,
                                             rrow: ROW_W'(s),
                                             fin: (s == last_hit)});
                end
            end
            FUNC_CLEAR:
                rows_held = 0;
            default:
                ;
        endcase
    endfunction

    function automatic request_t make_request(logic [1:0] fn, logic signed [VAL_W-1:0] xv,
                                              logic signed [VAL_W-1:0] yv,
                                              logic [ROW_W-1:0] prow);
        request_t rq;
        rq.fn   = fn;
        rq.xv   = xv;
        rq.yv   = yv;
        rq.prow = prow;
        return rq;
    endfunction

    // values near zero half the time so that ties turn up, else the extremes or a random word
    function automatic logic signed [VAL_W-1:0] pick_value();
        int near_zero;
        near_zero = int'($urandom_range(8));
        case ($urandom_range(9))
            0:             return {1'b1, {(VAL_W-1){1'b0}}};
            1:             return {1'b0, {(VAL_W-1){1'b1}}};
            2, 3, 4, 5, 6: return near_zero - 4;
            default:       return $urandom;
        endcase
    endfunction

    task automatic send_request(request_t rq);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid  <= 1'b1;
        func      <= rq.fn;
        x_value   <= rq.xv;
        y_value   <= rq.yv;
        probe_row <= rq.prow;
        do @(posedge clk); while (in_stall);
        predict_words(rq);
    endtask

    // hold off until every word has come back and the scan has surely finished
    task automatic drain_words();
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SCAN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_FIRST_OP)
            op_x = cmp_op_t'(val);
        else if (idx == REG_SECOND_OP)
            op_y = cmp_op_t'(val);
        @(posedge clk);
    endtask

    function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            fault_count++;
            $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
    begin : result_check
        join_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_words.size() == 0)
            begin
                fault_count++;
                $display("%0t ns: word expected none, got status %0d left %0d right %0d last %0d",
                         $time, status, row_id, partner_row, last);
            end
            else
            begin
                want = pending_words.pop_front();
                check_field("status", 8'(want.st), 8'(status));
                check_field("row_id", 8'(want.lrow), 8'(row_id));
                check_field("partner_row", 8'(want.rrow), 8'(partner_row));
                check_field("last", 8'(want.fin), 8'(last));
            end
        end
    end

    // reset operators (greater on x, less on y) over extreme rows
    task automatic test_reset_operators();
        int r;
        send_request(make_request(FUNC_LOAD, 0, 0, '0));
        send_request(make_request(FUNC_LOAD, {1'b0, {(VAL_W-1){1'b1}}},
                                  {1'b1, {(VAL_W-1){1'b0}}}, '1));
        send_request(make_request(FUNC_LOAD, {1'b1, {(VAL_W-1){1'b0}}},
                                  {1'b0, {(VAL_W-1){1'b1}}}, '0));
        send_request(make_request(FUNC_LOAD, -1, 1, '1));
        for (r = 0; r < 4; r++)
            send_request(make_request(FUNC_PROBE, '1, '0, ROW_W'(r)));
    endtask

    // probes beyond the table, unused selector, clear, empty table, spare registers, no match
    task automatic test_probe_corners();
        send_request(make_request(FUNC_PROBE, '0, '1, '1));
        send_request(make_request(FUNC_PROBE, '0, '0, ROW_W'(4)));
        send_request(make_request(FUNC_UNUSED, '1, '1, '1));
        send_request(make_request(FUNC_CLEAR, '0, '0, '0));
        send_request(make_request(FUNC_PROBE, '0, '0, '0));
        drain_words();
        write_reg(REG_FIRST_OP, CMP_LT);
        write_reg(REG_SECOND_OP, CMP_LT);
        write_reg(REG_SPARE_LO, 2'd3);
        write_reg(REG_SPARE_HI, 2'd1);
        send_request(make_request(FUNC_LOAD, 5, 5, '0));
        send_request(make_request(FUNC_PROBE, '0, '0, '0));
        send_request(make_request(FUNC_LOAD, 5, 5, '0));
    endtask

    // equal rows only match each other under the inclusive operators
    task automatic test_tie_operators();
        drain_words();
        write_reg(REG_FIRST_OP, CMP_LE);
        write_reg(REG_SECOND_OP, CMP_GE);
        send_request(make_request(FUNC_PROBE, '0, '0, ROW_W'(0)));
        send_request(make_request(FUNC_PROBE, '0, '0, ROW_W'(1)));
        send_request(make_request(FUNC_LOAD, 6, 4, '0));
        drain_words();
        write_reg(REG_FIRST_OP, CMP_GE);
        write_reg(REG_SECOND_OP, CMP_LE);
        send_request(make_request(FUNC_PROBE, '0, '0, ROW_W'(2)));
        send_request(make_request(FUNC_PROBE, '0, '0, ROW_W'(0)));
    endtask

    // random mix of load batches and probes, with clears, overfills, stray selectors and new operators
    task automatic test_random_traffic(int send_pct, int stall_pct, int phase);
        int round_no;
        int counted;
        int pick;
        int batch;
        logic [ROW_W-1:0] target;
        logic [CFG_DATA_W-1:0] op_a;
        logic [CFG_DATA_W-1:0] op_b;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        for (round_no = 0; round_no < 4; round_no++)
        begin
            drain_words();
            if (round_no == 0)
            begin
                op_a = CFG_DATA_W'(phase);
                op_b = CFG_DATA_W'(3 - phase);
            end
            else
            begin
                op_a = CFG_DATA_W'($urandom_range(3));
                op_b = CFG_DATA_W'($urandom_range(3));
            end
            write_reg(REG_FIRST_OP, op_a);
            write_reg(REG_SECOND_OP, op_b);
            if ($urandom_range(3) == 0)
                write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO,
                          CFG_DATA_W'($urandom_range(3)));
            counted = 0;
            while (counted < 22)
            begin
                pick = int'($urandom_range(99));
                if (pick < 40)
                begin
                    // now and then fill the table and push past the end
                    if ($urandom_range(19) == 0)
                        batch = MAX_ROWS_DEF - rows_held + int'($urandom_range(1, 2));
                    else
                        batch = int'($urandom_range(1, 6));
                    repeat (batch)
                        send_request(make_request(FUNC_LOAD, pick_value(), pick_value(),
                                                  ROW_W'($urandom)));
                    counted += batch;
                end
                else if (pick < 86)
                begin
                    batch = int'($urandom_range(1, 4));
                    repeat (batch)
                    begin
                        if (rows_held > 0 && $urandom_range(9) != 0)
                            target = ROW_W'($urandom_range(rows_held - 1));
                        else
                            target = ROW_W'($urandom_range(63));
                        send_request(make_request(FUNC_PROBE, pick_value(), pick_value(),
                                                  target));
                    end
                    counted += batch;
                end
                else if (pick < 93)
                begin
                    send_request(make_request(FUNC_CLEAR, pick_value(), pick_value(),
                                              ROW_W'($urandom)));
                    counted++;
                end
                else
                    send_request(make_request(FUNC_UNUSED, pick_value(), pick_value(),
                                              ROW_W'($urandom)));
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_operators();
        test_probe_corners();
        test_tie_operators();
        test_random_traffic(0, 0, 0);
        test_random_traffic(52, 0, 1);
        test_random_traffic(0, 52, 2);
        test_random_traffic(28, 28, 3);
        drain_words();
        if (fault_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[inequality_self_join.f]
+incdir+hdl
hdl/iesj_pkg.sv
hdl/iesj_cell.sv
hdl/inequality_self_join.sv
tb/sv/inequality_self_join_tb.sv
